>>> design/bps_pkg.sv
// Shared types and constants for the board power sequencer.
// Used by the step logic, the register file, the top level and the checker.
package bps_pkg;

   // Mode codes, as reported on the result channel.
   localparam logic [2:0] MODE_OFF  = 3'd0;
   localparam logic [2:0] MODE_BOOT = 3'd1;
   localparam logic [2:0] MODE_CONN = 3'd2;
   localparam logic [2:0] MODE_SHUT = 3'd3;
   localparam logic [2:0] MODE_ERR  = 3'd4;

   // Fault cause codes.
   localparam logic [2:0] CAUSE_NONE         = 3'd0;
   localparam logic [2:0] CAUSE_OFF_FAULT    = 3'd1;
   localparam logic [2:0] CAUSE_BOOT_FAULT   = 3'd2;
   localparam logic [2:0] CAUSE_BOOT_TIMEOUT = 3'd3;
   localparam logic [2:0] CAUSE_RUN_FAULT    = 3'd4;
   localparam logic [2:0] CAUSE_LINK_LOST    = 3'd5;
   localparam logic [2:0] CAUSE_HALT_FAULT   = 3'd6;

   // Register indexes (taken from paddr[2]) and reset values.
   localparam logic       REG_BOOT_TIMEOUT   = 1'b0;
   localparam logic       REG_SHUTDOWN_WAIT  = 1'b1;
   localparam logic [31:0] BOOT_TIMEOUT_RST  = 32'd60000;
   localparam logic [31:0] SHUTDOWN_WAIT_RST = 32'd10000;

   // Widths of the packed stream payloads.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // One tick item.
   typedef struct packed {
      logic [31:0] now_ms;
      logic        fault_clear;
      logic        halt_fault;
      logic        host_halt_flag;
      logic        halt_req;
      logic        run_fault;
      logic        link_up;
      logic        boot_fault;
      logic        boot_req;
      logic        off_fault;
      logic        force_off;
   } item_type;

   // One result item.
   typedef struct packed {
      logic [2:0] fault_cause;
      logic       clear_host_flag;
      logic       power_off_pulse;
      logic       halt_request;
      logic [2:0] mode;
   } result_type;

   // Control state carried from tick to tick (the entry stamp travels apart).
   typedef struct packed {
      logic [2:0] mode;
      logic       force_seen;
      logic       halt_request;
   } state_type;

   // Configured durations.
   typedef struct packed {
      logic [31:0] boot_timeout_ms;
      logic [31:0] shutdown_wait_ms;
   } cfg_type;

endpackage

>>> design/bps_csr.sv
// APB-style register file holding the boot timeout and shutdown wait.
// Depends on bps_pkg for the register indexes, reset values and cfg_type.
module bps_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output bps_pkg::cfg_type  cfg
);
   import bps_pkg::*;

   logic [31:0] boot_timeout_ff;
   logic [31:0] shutdown_wait_ff;
   logic        wr_en;

   // A write completes in the access phase; pready is tied high.
   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_timeout_ff  <= BOOT_TIMEOUT_RST;
         shutdown_wait_ff <= SHUTDOWN_WAIT_RST;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_BOOT_TIMEOUT:  boot_timeout_ff  <= pwdata;
            REG_SHUTDOWN_WAIT: shutdown_wait_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Read back the addressed register.
   always_comb begin
      unique case (paddr[2])
         REG_BOOT_TIMEOUT:  prdata = boot_timeout_ff;
         REG_SHUTDOWN_WAIT: prdata = shutdown_wait_ff;
         default:           prdata = '0;
      endcase
   end

   assign cfg.boot_timeout_ms  = boot_timeout_ff;
   assign cfg.shutdown_wait_ms = shutdown_wait_ff;

endmodule

>>> design/bps_step.sv
// Next-state and result logic for one tick of the power sequencer.
// Depends on bps_pkg for the mode and cause codes and the item, state and result types.
module bps_step #(
   parameter int TIME_BITS = 32
) (
   input  bps_pkg::item_type   item,
   input  bps_pkg::state_type  cur,
   input  logic [TIME_BITS-1:0] cur_stamp,
   input  bps_pkg::cfg_type    cfg,
   output bps_pkg::state_type  nxt,
   output logic [TIME_BITS-1:0] nxt_stamp,
   output bps_pkg::result_type result
);
   import bps_pkg::*;

   localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic                 boot_expired;
   logic                 shut_expired;

   // Elapsed time wraps at the timer width and compares unsigned.
   assign now_t        = TIME_BITS'(item.now_ms);
   assign elapsed      = now_t - cur_stamp;
   assign boot_expired = CMP_W'(elapsed) >= CMP_W'(cfg.boot_timeout_ms);
   assign shut_expired = CMP_W'(elapsed) >= CMP_W'(cfg.shutdown_wait_ms);

   always_comb begin
      logic [2:0] mode;
      logic       halt;
      logic       pulse_off;
      logic       pulse_clear;
      logic [2:0] cause;
      mode        = cur.mode;
      halt        = cur.halt_request;
      pulse_off   = 1'b0;
      pulse_clear = 1'b0;
      cause       = CAUSE_NONE;
      nxt_stamp   = cur_stamp;

      // A rising edge of the force level enters OFF before the mode handler.
      if (item.force_off && !cur.force_seen) begin
         mode        = MODE_OFF;
         pulse_off   = 1'b1;
         pulse_clear = 1'b1;
         halt        = 1'b0;
      end

      unique case (mode)
         MODE_OFF: begin
            // An off fault enters ERROR; a boot request then still wins.
            if (item.off_fault) begin
               mode        = MODE_ERR;
               pulse_clear = 1'b1;
               halt        = 1'b0;
               cause       = CAUSE_OFF_FAULT;
            end
            if (item.boot_req) begin
               mode      = MODE_BOOT;
               nxt_stamp = now_t;
            end
         end
         MODE_BOOT: begin
            priority if (item.boot_fault) begin
               mode        = MODE_ERR;
               pulse_clear = 1'b1;
               halt        = 1'b0;
               cause       = CAUSE_BOOT_FAULT;
            end else if (boot_expired) begin
               mode        = MODE_ERR;
               pulse_clear = 1'b1;
               halt        = 1'b0;
               cause       = CAUSE_BOOT_TIMEOUT;
            end else if (item.link_up) begin
               mode = MODE_CONN;
            end
         end
         MODE_CONN: begin
            priority if (item.run_fault) begin
               mode        = MODE_ERR;
               pulse_clear = 1'b1;
               halt        = 1'b0;
               cause       = CAUSE_RUN_FAULT;
            end else if (item.halt_req) begin
               mode        = MODE_SHUT;
               pulse_clear = 1'b1;
               halt        = 1'b1;
               nxt_stamp   = now_t;
            end else if (!item.link_up) begin
               mode        = MODE_ERR;
               pulse_clear = 1'b1;
               halt        = 1'b0;
               cause       = CAUSE_LINK_LOST;
            end else if (item.host_halt_flag) begin
               mode        = MODE_SHUT;
               pulse_clear = 1'b1;
               halt        = 1'b1;
               nxt_stamp   = now_t;
            end
         end
         MODE_SHUT: begin
            priority if (item.halt_fault) begin
               mode        = MODE_ERR;
               pulse_clear = 1'b1;
               halt        = 1'b0;
               cause       = CAUSE_HALT_FAULT;
            end else if (shut_expired) begin
               mode        = MODE_OFF;
               pulse_off   = 1'b1;
               pulse_clear = 1'b1;
               halt        = 1'b0;
            end
         end
         MODE_ERR: begin
            if (item.fault_clear) begin
               mode        = MODE_OFF;
               pulse_off   = 1'b1;
               pulse_clear = 1'b1;
               halt        = 1'b0;
            end
         end
         default: ;
      endcase

      nxt.mode                = mode;
      nxt.force_seen          = item.force_off;
      nxt.halt_request        = halt;
      result.mode             = mode;
      result.halt_request     = halt;
      result.power_off_pulse  = pulse_off;
      result.clear_host_flag  = pulse_clear;
      result.fault_cause      = cause;
   end

endmodule

>>> design/board_power_sequencer.sv
// Board power sequencer: a tick accepted on req_ is held in an input register, runs through the
// step logic and lands in the result register, which offers it on rsp_. Throughput one tick per
// cycle while rsp_tready keeps the result register draining; the next tick enters as one leaves.
// Synchronous active-high reset: mode OFF, stamp zero, force level and halt request
// low, boot timeout 60000 ms, shutdown wait 10000 ms, both pipeline stages empty.
module board_power_sequencer #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Tick channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] force_off, [1] off_fault, [2] boot_req, [3] boot_fault, [4] link_up,
   // [5] run_fault, [6] halt_req, [7] host_halt_flag, [8] halt_fault,
   // [9] fault_clear, [41:10] now_ms, [47:42] zero
   input  logic [47:0] req_tdata,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] mode, [3] halt_request, [4] power_off_pulse, [5] clear_host_flag,
   // [8:6] fault_cause, [15:9] zero
   output logic [15:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bps_pkg::*;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   item_type             in_item_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   result_type           out_result_ff;
   state_type            state_ff;
   state_type            state_in;
   logic [TIME_BITS-1:0] stamp_ff;
   logic [TIME_BITS-1:0] stamp_in;
   result_type           step_result;
   cfg_type              cfg;
   logic                 advance;
   logic                 req_xfer;

   assign csr_pready = 1'b1;

   bps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   bps_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .item      (in_item_ff),
      .cur       (state_ff),
      .cur_stamp (stamp_ff),
      .cfg       (cfg),
      .nxt       (state_in),
      .nxt_stamp (stamp_in),
      .result    (step_result)
   );

   // The tick in the input register moves on when the result register is free.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_xfer     = req_tvalid && req_tready;
   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= item_type'(req_tdata[$bits(item_type)-1:0]);
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   // Sequencer state updates once per tick, as it leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= MODE_OFF;
         state_ff.force_seen   <= 1'b0;
         state_ff.halt_request <= 1'b0;
         stamp_ff              <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         stamp_ff <= stamp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(result_type))'(0), out_result_ff};

endmodule

>>> design/bps_checker.sv
// Port-level checks for the board power sequencer, bound to the top level.
// Depends on bps_pkg for the mode codes.
module bps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);
   import bps_pkg::*;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The halt request is high exactly while shutting down.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3] == (rsp_tdata[2:0] == MODE_SHUT)))
      else $error("halt request does not match shutdown mode");

   // Entering OFF always clears the host flag as well.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[5])
      else $error("power-off pulse without host flag clear");

   // A fault entry clears the host flag and never leaves a halt request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:6] != CAUSE_NONE) |-> rsp_tdata[5] && !rsp_tdata[3])
      else $error("fault cause without error entry actions");

   // The reported mode is one of the five modes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] == MODE_OFF) || (rsp_tdata[2:0] == MODE_BOOT) ||
         (rsp_tdata[2:0] == MODE_CONN) || (rsp_tdata[2:0] == MODE_SHUT) ||
         (rsp_tdata[2:0] == MODE_ERR))
      else $error("mode code out of range");

endmodule

bind board_power_sequencer bps_checker u_bps_checker (.*);

>>> bench/board_power_sequencer_tb.sv
// Self-checking testbench for the board power sequencer: tick transfers in, results out.
// Depends on bps_pkg and board_power_sequencer, which needs bps_csr and bps_step.
// A local mode and timer predictor checks every result field by field.
module board_power_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bps_pkg::*;

   // Run length guard, in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Event flag masks for building tick items, low ten bits of an item.
   localparam logic [9:0] F_NONE       = 10'h000;
   localparam logic [9:0] F_FORCE      = 10'h001;
   localparam logic [9:0] F_OFF_FAULT  = 10'h002;
   localparam logic [9:0] F_BOOT_REQ   = 10'h004;
   localparam logic [9:0] F_BOOT_FAULT = 10'h008;
   localparam logic [9:0] F_LINK       = 10'h010;
   localparam logic [9:0] F_RUN_FAULT  = 10'h020;
   localparam logic [9:0] F_HALT_REQ   = 10'h040;
   localparam logic [9:0] F_HOST_HALT  = 10'h080;
   localparam logic [9:0] F_HALT_FAULT = 10'h100;
   localparam logic [9:0] F_CLEAR      = 10'h200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   board_power_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Predicted sequencer state and configuration.
   logic [2:0]  seq_mode = MODE_OFF;
   logic [31:0] seq_stamp = '0;
   logic        seq_force_seen = 1'b0;
   logic        seq_halt_request = 1'b0;
   logic [31:0] cfg_boot_timeout = BOOT_TIMEOUT_RST;
   logic [31:0] cfg_shutdown_wait = SHUTDOWN_WAIT_RST;

   // Per-tick outputs being built by the predictor.
   logic [31:0] tick_now;
   logic        tick_power_off;
   logic        tick_clear_flag;
   logic [2:0]  tick_cause;

   // Stimulus shaping.
   bit          send_idle_en = 1'b1;
   bit          recv_idle_en = 1'b1;
   logic [31:0] wall_ms = '0;
   logic        force_level = 1'b0;

   result_type  expected_results[$];
   int unsigned errors = 0;
   int unsigned cycle_count = 0;

   // Entry actions of a mode.
   function automatic void enter_mode(logic [2:0] m);
      seq_mode = m;
      case (m)
         MODE_OFF: begin
            tick_power_off = 1'b1;
            tick_clear_flag = 1'b1;
            seq_halt_request = 1'b0;
         end
         MODE_BOOT: begin
            seq_stamp = tick_now;
         end
         MODE_SHUT: begin
            tick_clear_flag = 1'b1;
            seq_halt_request = 1'b1;
            seq_stamp = tick_now;
         end
         MODE_ERR: begin
            tick_clear_flag = 1'b1;
            seq_halt_request = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic void raise_fault(logic [2:0] c);
      enter_mode(MODE_ERR);
      tick_cause = c;
   endfunction

   // Advances the predicted sequencer by one tick and returns its result.
   function automatic result_type predict_tick(item_type t);
      result_type  r;
      logic [31:0] elapsed;
      tick_now = t.now_ms;
      tick_power_off = 1'b0;
      tick_clear_flag = 1'b0;
      tick_cause = CAUSE_NONE;
      if (t.force_off && !seq_force_seen) enter_mode(MODE_OFF);
      seq_force_seen = t.force_off;
      // Wrapping difference from the entry stamp.
      elapsed = tick_now - seq_stamp;
      case (seq_mode)
         MODE_OFF: begin
            // An off fault with a boot request still ends in BOOTING.
            if (t.off_fault) raise_fault(CAUSE_OFF_FAULT);
            if (t.boot_req) enter_mode(MODE_BOOT);
         end
         MODE_BOOT: begin
            if (t.boot_fault) raise_fault(CAUSE_BOOT_FAULT);
            else if (elapsed >= cfg_boot_timeout) raise_fault(CAUSE_BOOT_TIMEOUT);
            else if (t.link_up) enter_mode(MODE_CONN);
         end
         MODE_CONN: begin
            if (t.run_fault) raise_fault(CAUSE_RUN_FAULT);
            else if (t.halt_req) enter_mode(MODE_SHUT);
            else if (!t.link_up) raise_fault(CAUSE_LINK_LOST);
            else if (t.host_halt_flag) enter_mode(MODE_SHUT);
         end
         MODE_SHUT: begin
            if (t.halt_fault) raise_fault(CAUSE_HALT_FAULT);
            else if (elapsed >= cfg_shutdown_wait) enter_mode(MODE_OFF);
         end
         MODE_ERR: begin
            if (t.fault_clear) enter_mode(MODE_OFF);
         end
         default: ;
      endcase
      r.mode = seq_mode;
      r.halt_request = seq_halt_request;
      r.power_off_pulse = tick_power_off;
      r.clear_host_flag = tick_clear_flag;
      r.fault_cause = tick_cause;
      return r;
   endfunction

   function automatic item_type make_tick(logic [9:0] flags, logic [31:0] now);
      return item_type'({now, flags});
   endfunction

   function automatic bit chance(int unsigned pct);
      return $urandom_range(99) < pct;
   endfunction

   // Mostly well-formed ticks that follow the predicted mode, with some pure noise.
   function automatic item_type random_tick(int unsigned step_max);
      item_type    t;
      logic [63:0] raw;
      if (chance(8)) begin
         raw = {$urandom, $urandom};
         t = item_type'(raw[41:0]);
         force_level = t.force_off;
      end else begin
         if (chance(3)) force_level = !force_level;
         t.force_off = force_level;
         t.off_fault = chance(6);
         t.boot_req = chance(40);
         t.boot_fault = chance(3);
         t.link_up = (seq_mode == MODE_CONN) ? chance(96) : chance(25);
         t.run_fault = chance(2);
         t.halt_req = chance(4);
         t.host_halt_flag = chance(4);
         t.halt_fault = chance(3);
         t.fault_clear = chance(40);
         if (chance(2)) wall_ms = $urandom;
         else wall_ms = wall_ms + $urandom_range(step_max, 0);
         t.now_ms = wall_ms;
      end
      return t;
   endfunction

   // Sends one tick and records its expected result once the transfer happens.
   task automatic send_tick(item_type t);
      while (send_idle_en && chance(31)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_tick(t));
   endtask

   // Stops sending and waits until every pending result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_BOOT_TIMEOUT) cfg_boot_timeout = value;
      else cfg_shutdown_wait = value;
   endtask

   task automatic set_config(logic [31:0] boot_ms, logic [31:0] shut_ms);
      drain_results();
      csr_write(REG_BOOT_TIMEOUT, boot_ms);
      csr_write(REG_SHUTDOWN_WAIT, shut_ms);
   endtask

   // Walks every transition and priority with the reset durations.
   task automatic test_directed_sequences();
      send_tick(make_tick(F_NONE, 32'd0));
      send_tick(make_tick(F_OFF_FAULT, 32'd10));
      send_tick(make_tick(F_CLEAR, 32'd20));
      // Off fault together with a boot request.
      send_tick(make_tick(F_OFF_FAULT | F_BOOT_REQ, 32'd30));
      // Boot fault wins over the link coming up.
      send_tick(make_tick(F_BOOT_FAULT | F_LINK, 32'd40));
      send_tick(make_tick(F_CLEAR, 32'd50));
      send_tick(make_tick(F_BOOT_REQ, 32'd100));
      // Timeout wins over the link at exactly the boot limit.
      send_tick(make_tick(F_LINK, 32'd60100));
      send_tick(make_tick(F_CLEAR, 32'd60200));
      // Boot across the timestamp wrap.
      send_tick(make_tick(F_BOOT_REQ, 32'hFFFF_FF00));
      send_tick(make_tick(F_NONE, 32'h0000_0100));
      send_tick(make_tick(F_LINK, 32'h0000_0200));
      send_tick(make_tick(F_LINK | F_HOST_HALT, 32'h0000_0300));
      send_tick(make_tick(F_HALT_FAULT, 32'h0000_0400));
      send_tick(make_tick(F_CLEAR | F_BOOT_REQ, 32'd5000));
      send_tick(make_tick(F_BOOT_REQ, 32'd5001));
      send_tick(make_tick(F_LINK, 32'd5002));
      // Run fault wins over a halt request.
      send_tick(make_tick(F_RUN_FAULT | F_HALT_REQ | F_LINK, 32'd5003));
      send_tick(make_tick(F_CLEAR, 32'd5004));
      send_tick(make_tick(F_BOOT_REQ, 32'd5005));
      send_tick(make_tick(F_LINK, 32'd5006));
      // Halt request wins over a lost link.
      send_tick(make_tick(F_HALT_REQ, 32'd5007));
      send_tick(make_tick(F_NONE, 32'd15006));
      send_tick(make_tick(F_NONE, 32'd15007));
      send_tick(make_tick(F_BOOT_REQ, 32'd15100));
      send_tick(make_tick(F_LINK, 32'd15101));
      send_tick(make_tick(F_NONE, 32'd15102));
      // Force edge leaves ERROR and the off checks run in the same tick.
      send_tick(make_tick(F_FORCE | F_BOOT_REQ, 32'd15200));
      // Force held high is no edge.
      send_tick(make_tick(10'h3FF, 32'hFFFF_FFFF));
   endtask

   // Duration limits at zero and at the top of the range.
   task automatic test_timer_extremes();
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tick(make_tick(F_NONE, 32'd900));
      send_tick(make_tick(F_FORCE | F_BOOT_REQ, 32'd1000));
      send_tick(make_tick(F_FORCE, 32'd998));
      send_tick(make_tick(F_FORCE, 32'd999));
      send_tick(make_tick(F_CLEAR, 32'd0));
      set_config(32'd0, 32'd0);
      send_tick(make_tick(F_BOOT_REQ, 32'd5));
      send_tick(make_tick(F_LINK, 32'd5));
      send_tick(make_tick(F_CLEAR, 32'd6));
      set_config(32'hFFFF_FFFF, 32'd0);
      send_tick(make_tick(F_BOOT_REQ, 32'd7));
      send_tick(make_tick(F_LINK, 32'd7));
      send_tick(make_tick(F_LINK | F_HALT_REQ, 32'd8));
      send_tick(make_tick(F_NONE, 32'd8));
   endtask

   task automatic run_phase(logic [31:0] boot_ms, logic [31:0] shut_ms,
                            int unsigned step_max, bit idle_en, int unsigned count);
      set_config(boot_ms, shut_ms);
      send_idle_en = idle_en;
      recv_idle_en = idle_en;
      for (int unsigned i = 0; i < count; i++) begin
         // Halfway through, hold off until the pipeline is empty.
         if (i == count / 2) drain_results();
         send_tick(random_tick(step_max));
      end
   endtask

   // Random ticks under several configurations, one stretch without idling.
   task automatic test_random_phases();
      run_phase(32'd300, 32'd200, 40, 1'b1, 230);
      run_phase(32'hFFFF_FFFF, 32'd0, 50, 1'b1, 230);
      run_phase(32'd0, 32'hFFFF_FFFF, 50, 1'b1, 230);
      run_phase($urandom_range(1000, 1), $urandom_range(1000, 1), 100, 1'b0, 230);
      run_phase($urandom, $urandom, 5000, 1'b1, 230);
      run_phase(BOOT_TIMEOUT_RST, SHUTDOWN_WAIT_RST, 3000, 1'b1, 230);
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Result side: random stalls and a field-by-field compare of each transfer.
   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[8:0]);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("mode", want.mode, got.mode);
            check_field("halt_request", want.halt_request, got.halt_request);
            check_field("power_off_pulse", want.power_off_pulse, got.power_off_pulse);
            check_field("clear_host_flag", want.clear_host_flag, got.clear_host_flag);
            check_field("fault_cause", want.fault_cause, got.fault_cause);
            check_field("padding", 0, rsp_tdata[15:9]);
         end
      end
      rsp_tready <= recv_idle_en ? !chance(31) : 1'b1;
   end

   // Run guard.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_sequences();
      test_timer_extremes();
      test_random_phases();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
design/bps_pkg.sv
design/bps_csr.sv
design/bps_step.sv
design/board_power_sequencer.sv
design/bps_checker.sv
bench/board_power_sequencer_tb.sv
